@@ hw/rtl/gcdisp_pkg.sv @@
// Shared types and constants for the greedy change dispenser.
// Holds the word formats, result codes, controller states and the control/status bundles.
// No dependencies.
package gcdisp_pkg;

  localparam int NUM_SLOTS = 8;   // denomination registers in the register map
  localparam int IDX_W     = 3;   // denomination index width
  localparam int VAL_W     = 16;  // denomination value width
  localparam int AMT_W     = 20;  // money amount width
  localparam int STK_W     = 8;   // stock count width

  localparam logic [VAL_W-1:0] DENOM_RESET [NUM_SLOTS] = '{
    16'd1, 16'd2, 16'd5, 16'd10, 16'd20, 16'd50, 16'd100, 16'd200
  };

  typedef enum logic [2:0] {
    ST_COIN      = 3'd0,
    ST_UNDER     = 3'd1,
    ST_EXACT     = 3'd2,
    ST_INEXACT   = 3'd3,
    ST_EXHAUSTED = 3'd4,
    ST_LOADED    = 3'd5,
    ST_CAPPED    = 3'd6
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_STEP
  } state_t;

  typedef struct packed {
    logic             action;
    logic [AMT_W-1:0] total_due;
    logic [AMT_W-1:0] amount_paid;
    logic [IDX_W-1:0] denom_index;
    logic [STK_W-1:0] stock_count;
  } in_word_t;

  typedef struct packed {
    status_t          status;
    logic [IDX_W-1:0] coin_index;
    logic [VAL_W-1:0] coin_value;
    logic [VAL_W-1:0] excess;
    logic             last;
  } out_word_t;

  // Controller to datapath commands
  typedef struct packed {
    logic    capture;
    logic    load_stock;
    logic    start_run;
    logic    scan;
    logic    take_pick;
    logic    take_fb;
    logic    emit;
    status_t status;
    logic    last;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic action;
    logic under;
    logic exact;
    logic found;
    logic fb_found;
    logic rem_clear;
  } sts_t;

endpackage

@@ hw/rtl/gcdisp_ctrl.sv @@
// Controller state machine for the greedy change dispenser.
// Sequences decode, scan and dispense steps and counts coins per run; uses gcdisp_pkg.
module gcdisp_ctrl #(
  parameter int MAX_COINS = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  gcdisp_pkg::sts_t  sts,
  output gcdisp_pkg::cmd_t  cmd
);
  import gcdisp_pkg::*;

  localparam int CW = (MAX_COINS > 1) ? $clog2(MAX_COINS) : 1;
  localparam logic [CW-1:0] CAP_AT = CW'(MAX_COINS - 1);

  state_t        state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          at_cap;

  assign busy   = (state_r != S_IDLE);
  assign at_cap = (cnt_r == CAP_AT);

  // Hold state and coin count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (start) state_nxt = S_DECODE;
      end
      S_DECODE: begin
        if (sts.action || sts.under || sts.exact) state_nxt = S_IDLE;
        else state_nxt = S_SCAN;
      end
      S_SCAN: state_nxt = S_STEP;
      S_STEP: begin
        if (sts.found && !sts.rem_clear && !at_cap) state_nxt = S_SCAN;
        else state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands and coin count
  always_comb begin
    cmd     = '0;
    cnt_nxt = cnt_r;
    case (state_r)
      S_IDLE: begin
        cmd.capture = start;
        if (start) cnt_nxt = '0;
      end
      S_DECODE: begin
        if (sts.action) begin
          cmd.load_stock = 1'b1;
          cmd.emit       = 1'b1;
          cmd.status     = ST_LOADED;
          cmd.last       = 1'b1;
        end else if (sts.under) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_UNDER;
          cmd.last   = 1'b1;
        end else if (sts.exact) begin
          cmd.emit   = 1'b1;
          cmd.status = ST_EXACT;
          cmd.last   = 1'b1;
        end else begin
          cmd.start_run = 1'b1;
        end
      end
      S_SCAN: cmd.scan = 1'b1;
      S_STEP: begin
        cmd.emit = 1'b1;
        if (sts.found) begin
          cmd.take_pick = 1'b1;
          if (sts.rem_clear) begin
            cmd.status = ST_COIN;
            cmd.last   = 1'b1;
          end else if (at_cap) begin
            cmd.status = ST_CAPPED;
            cmd.last   = 1'b1;
          end else begin
            cmd.status = ST_COIN;
            cmd.last   = 1'b0;
            cnt_nxt    = cnt_r + 1'b1;
          end
        end else if (sts.fb_found) begin
          cmd.take_fb = 1'b1;
          cmd.status  = ST_INEXACT;
          cmd.last    = 1'b1;
        end else begin
          cmd.status = ST_EXHAUSTED;
          cmd.last   = 1'b1;
        end
      end
      default: cmd = '0;
    endcase
  end

endmodule

@@ hw/rtl/gcdisp_dp.sv @@
// Datapath for the greedy change dispenser: denomination registers, coin stock,
// remaining change, denomination scan and the result register; uses gcdisp_pkg.
module gcdisp_dp #(
  parameter int NUM_DENOMS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_we,
  input  logic [gcdisp_pkg::IDX_W-1:0]        cfg_idx,
  input  logic [gcdisp_pkg::VAL_W-1:0]        cfg_wdata,
  input  gcdisp_pkg::in_word_t                in_data,
  input  gcdisp_pkg::cmd_t                    cmd,
  output gcdisp_pkg::sts_t                    sts,
  output logic                                out_valid,
  output gcdisp_pkg::out_word_t               out_data
);
  import gcdisp_pkg::*;

  logic [VAL_W-1:0] denom_r [NUM_SLOTS];
  logic [STK_W-1:0] stock_r [NUM_SLOTS];
  in_word_t         item_r;
  logic [AMT_W-1:0] rem_r;
  logic [IDX_W-1:0] pick_idx_r, pick_idx_nxt;
  logic [IDX_W-1:0] fb_idx_r, fb_idx_nxt;
  logic [VAL_W-1:0] pick_val_r, pick_val_nxt;
  logic [VAL_W-1:0] fb_val_r, fb_val_nxt;
  logic             found_r, found_nxt;
  logic             fb_found_r, fb_found_nxt;
  logic             valid_r;
  out_word_t        out_r, out_nxt;
  logic [AMT_W:0]   diff;
  logic [NUM_SLOTS-1:0] usable;
  logic             load_ok;

  assign diff    = {1'b0, item_r.amount_paid} - {1'b0, item_r.total_due};
  assign load_ok = ({1'b0, item_r.denom_index} < (IDX_W+1)'(NUM_DENOMS));

  // Report status to the controller
  assign sts.action    = item_r.action;
  assign sts.under     = diff[AMT_W];
  assign sts.exact     = (item_r.amount_paid == item_r.total_due);
  assign sts.found     = found_r;
  assign sts.fb_found  = fb_found_r;
  assign sts.rem_clear = (rem_r == {{(AMT_W-VAL_W){1'b0}}, pick_val_r});

  // Denomination registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) denom_r[i] <= DENOM_RESET[i];
    end else if (cfg_we) begin
      denom_r[cfg_idx] <= cfg_wdata;
    end
  end

  // Coin stock: load or decrement the picked or fallback slot
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_SLOTS; i++) stock_r[i] <= '0;
    end else begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
        if (cmd.load_stock && load_ok && item_r.denom_index == IDX_W'(i)) begin
          stock_r[i] <= item_r.stock_count;
        end else if ((cmd.take_pick && pick_idx_r == IDX_W'(i)) ||
                     (cmd.take_fb && fb_idx_r == IDX_W'(i))) begin
          stock_r[i] <= stock_r[i] - 1'b1;
        end
      end
    end
  end

  // Slots that can pay out a coin
  always_comb begin
    for (int i = 0; i < NUM_SLOTS; i++) begin
      usable[i] = (i < NUM_DENOMS) && (denom_r[i] != '0) && (stock_r[i] != '0);
    end
  end

  // Scan: highest usable slot that fits, and lowest usable slot as fallback
  always_comb begin
    pick_idx_nxt = '0;
    pick_val_nxt = '0;
    found_nxt    = 1'b0;
    fb_idx_nxt   = '0;
    fb_val_nxt   = '0;
    fb_found_nxt = 1'b0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (usable[i] && ({{(AMT_W-VAL_W){1'b0}}, denom_r[i]} <= rem_r)) begin
        pick_idx_nxt = IDX_W'(i);
        pick_val_nxt = denom_r[i];
        found_nxt    = 1'b1;
      end
    end
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (usable[i]) begin
        fb_idx_nxt   = IDX_W'(i);
        fb_val_nxt   = denom_r[i];
        fb_found_nxt = 1'b1;
      end
    end
  end

  // Capture the item, hold scan results and advance the remaining change
  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_data;
    if (cmd.start_run) begin
      rem_r <= diff[AMT_W-1:0];
    end else if (cmd.take_pick) begin
      rem_r <= rem_r - {{(AMT_W-VAL_W){1'b0}}, pick_val_r};
    end
    if (cmd.scan) begin
      pick_idx_r <= pick_idx_nxt;
      pick_val_r <= pick_val_nxt;
      fb_idx_r   <= fb_idx_nxt;
      fb_val_r   <= fb_val_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      found_r    <= 1'b0;
      fb_found_r <= 1'b0;
    end else if (cmd.scan) begin
      found_r    <= found_nxt;
      fb_found_r <= fb_found_nxt;
    end
  end

  // Build the result word
  always_comb begin
    out_nxt        = '0;
    out_nxt.status = cmd.status;
    out_nxt.last   = cmd.last;
    case (cmd.status)
      ST_COIN, ST_CAPPED: begin
        out_nxt.coin_index = pick_idx_r;
        out_nxt.coin_value = pick_val_r;
      end
      ST_INEXACT: begin
        out_nxt.coin_index = fb_idx_r;
        out_nxt.coin_value = fb_val_r;
        out_nxt.excess     = fb_val_r - rem_r[VAL_W-1:0];
      end
      default: begin
        out_nxt.coin_index = '0;
      end
    endcase
  end

  // Result register: one cycle strobe
  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= cmd.emit;
    if (cmd.emit) out_r <= out_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = out_r;

endmodule

@@ hw/rtl/greedy_change_dispenser.sv @@
// Greedy change dispenser top level: controller plus datapath; uses gcdisp_pkg.
// A load, underpaid or exact word gives its result from the decode state; in a change run
// each result follows a scan state and a step state of the controller.
// The next word is taken once the controller is back in idle with busy low; the receiver
// cannot stall, each result strobes once.
// Synchronous reset restores the default denominations and empties all stock.
module greedy_change_dispenser #(
  parameter int NUM_DENOMS = 8,
  parameter int MAX_COINS  = 64
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  gcdisp_pkg::in_word_t          in_data,
  output logic                          out_valid,
  output gcdisp_pkg::out_word_t         out_data,
  input  logic                          cfg_we,
  input  logic [gcdisp_pkg::IDX_W-1:0]  cfg_idx,
  input  logic [gcdisp_pkg::VAL_W-1:0]  cfg_wdata
);
  import gcdisp_pkg::*;

  cmd_t cmd;
  sts_t sts;

  gcdisp_ctrl #(
    .MAX_COINS (MAX_COINS)
  ) u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  gcdisp_dp #(
    .NUM_DENOMS (NUM_DENOMS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_idx   (cfg_idx),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule
